// ----- src/ldhc_pkg.sv -----
package ldhc_pkg;

    typedef enum logic [1:0] {
        HZ_NONE  = 2'd0,
        HZ_RW    = 2'd1,
        HZ_READ  = 2'd2,
        HZ_WRITE = 2'd3
    } t_hazard;

    // register touch flags for the watched register
    typedef struct packed {
        logic rd;
        logic wr;
    } t_access;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP2    = 6'h12;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LWL     = 6'h22;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_LWR     = 6'h26;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SWL     = 6'h2a;
    localparam logic [5:0] OP_SW      = 6'h2b;
    localparam logic [5:0] OP_SWR     = 6'h2e;
    localparam logic [5:0] OP_LWC2    = 6'h32;
    localparam logic [5:0] OP_SWC2    = 6'h3a;

    // SPECIAL funct codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1a;
    localparam logic [5:0] FN_DIVU    = 6'h1b;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    // REGIMM rt codes
    localparam logic [4:0] RI_BLTZ    = 5'h00;
    localparam logic [4:0] RI_BGEZ    = 5'h01;
    localparam logic [4:0] RI_BLTZL   = 5'h02;
    localparam logic [4:0] RI_BLTZAL  = 5'h10;
    localparam logic [4:0] RI_BGEZAL  = 5'h11;
    localparam logic [4:0] RI_BLTZALL = 5'h12;

    // coprocessor move codes in rs
    localparam logic [4:0] CO_MF      = 5'h00;
    localparam logic [4:0] CO_CF      = 5'h02;
    localparam logic [4:0] CO_MT      = 5'h04;
    localparam logic [4:0] CO_CT      = 5'h06;

    localparam logic [4:0] REG_RA     = 5'd31;

    function automatic t_hazard classify(input t_access acc);
        t_hazard h;
        case ({acc.rd, acc.wr})
            2'b11:   h = HZ_RW;
            2'b10:   h = HZ_READ;
            2'b01:   h = HZ_WRITE;
            default: h = HZ_NONE;
        endcase
        return h;
    endfunction

endpackage

// ----- src/load_delay_hazard_classifier.sv -----
// Load delay slot hazard classifier.
//
// Input: pulse i_start with the pending load's target register (i_load_reg)
// and the delay slot instruction (i_instr_word). A beat is taken at every
// rising edge with i_start high and o_busy low; o_busy stays low, so a new
// beat may enter every cycle.
//
// Output: o_strobe is high for one cycle with o_hazard_class
// (0 none, 1 read and written, 2 read only, 3 written only).
// Each beat passes one input register, the field decoder and register
// compares, then the result register.
// Throughput is one beat per cycle.
//
// Reset (synchronous, i_rst_n low) drops all beats in flight; no strobe
// follows until new beats enter. The receiver has no back pressure and
// must take every strobed result.
module load_delay_hazard_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [4:0]  i_load_reg,
    input  logic [31:0] i_instr_word,
    output logic        o_strobe,
    output logic [1:0]  o_hazard_class
);

    logic               r_in_vld;
    logic [4:0]         r_load_reg;
    logic [31:0]        r_instr_word;
    logic               r_out_vld;
    ldhc_pkg::t_hazard  r_class;
    ldhc_pkg::t_hazard  n_class;
    ldhc_pkg::t_access  dec_access;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= i_start & ~o_busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_load_reg   <= i_load_reg;
            r_instr_word <= i_instr_word;
        end
        r_class <= n_class;
    end

    ldhc_decode u_decode (
        .i_load_reg   (r_load_reg),
        .i_instr_word (r_instr_word),
        .o_access     (dec_access)
    );

    assign n_class        = ldhc_pkg::classify(dec_access);
    assign o_strobe       = r_out_vld;
    assign o_hazard_class = r_class;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_strobe)
        else $error("accepted beat produced no strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |=> !o_strobe)
        else $error("strobe without an accepted beat");

    a_nop_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && (r_instr_word == 32'd0) |=> (o_hazard_class == ldhc_pkg::HZ_NONE))
        else $error("NOP classified as a hazard");

    a_merge_load_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && (r_instr_word[31:26] == ldhc_pkg::OP_LWL ||
                     r_instr_word[31:26] == ldhc_pkg::OP_LWR) &&
        (r_instr_word[20:16] == r_load_reg)
        |=> (o_hazard_class == ldhc_pkg::HZ_WRITE))
        else $error("LWL/LWR target match not reported as write only");

endmodule

// ----- src/ldhc_decode.sv -----
module ldhc_decode (
    input  logic [4:0]            i_load_reg,
    input  logic [31:0]           i_instr_word,
    output ldhc_pkg::t_access     o_access
);

    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rs;
    logic [4:0] rt;
    logic       m_rs;
    logic       m_rt;
    logic       m_rd;

    assign op   = i_instr_word[31:26];
    assign fn   = i_instr_word[5:0];
    assign rs   = i_instr_word[25:21];
    assign rt   = i_instr_word[20:16];
    assign m_rs = (rs == i_load_reg);
    assign m_rt = (rt == i_load_reg);
    assign m_rd = (i_instr_word[15:11] == i_load_reg);

    always_comb begin
        o_access = '0;
        if (i_instr_word != 32'd0) begin
            case (op)
                ldhc_pkg::OP_SPECIAL: begin
                    case (fn)
                        ldhc_pkg::FN_SLL, ldhc_pkg::FN_SRL, ldhc_pkg::FN_SRA: begin
                            o_access.rd = m_rt;
                            o_access.wr = m_rd;
                        end
                        ldhc_pkg::FN_JR, ldhc_pkg::FN_MTHI, ldhc_pkg::FN_MTLO: begin
                            o_access.rd = m_rs;
                        end
                        ldhc_pkg::FN_JALR: begin
                            o_access.rd = m_rs;
                            o_access.wr = m_rd;
                        end
                        ldhc_pkg::FN_SLLV, ldhc_pkg::FN_SRLV, ldhc_pkg::FN_SRAV,
                        ldhc_pkg::FN_ADD, ldhc_pkg::FN_ADDU, ldhc_pkg::FN_SUB,
                        ldhc_pkg::FN_SUBU, ldhc_pkg::FN_AND, ldhc_pkg::FN_OR,
                        ldhc_pkg::FN_XOR, ldhc_pkg::FN_NOR, ldhc_pkg::FN_SLT,
                        ldhc_pkg::FN_SLTU: begin
                            o_access.rd = m_rs | m_rt;
                            o_access.wr = m_rd;
                        end
                        ldhc_pkg::FN_MFHI, ldhc_pkg::FN_MFLO: begin
                            o_access.wr = m_rd;
                        end
                        ldhc_pkg::FN_MULT, ldhc_pkg::FN_MULTU, ldhc_pkg::FN_DIV,
                        ldhc_pkg::FN_DIVU: begin
                            o_access.rd = m_rs | m_rt;
                        end
                        default: o_access = '0;
                    endcase
                end
                ldhc_pkg::OP_REGIMM: begin
                    // only the less-than-zero branch forms are decoded
                    case (rt)
                        ldhc_pkg::RI_BLTZ, ldhc_pkg::RI_BLTZL,
                        ldhc_pkg::RI_BLTZAL, ldhc_pkg::RI_BLTZALL: o_access.rd = m_rs;
                        default:                                   o_access = '0;
                    endcase
                end
                ldhc_pkg::OP_JAL: begin
                    o_access.wr = (i_load_reg == ldhc_pkg::REG_RA);
                end
                ldhc_pkg::OP_BEQ, ldhc_pkg::OP_BNE: begin
                    o_access.rd = m_rs | m_rt;
                end
                ldhc_pkg::OP_BLEZ, ldhc_pkg::OP_BGTZ,
                ldhc_pkg::OP_LWC2, ldhc_pkg::OP_SWC2: begin
                    o_access.rd = m_rs;
                end
                ldhc_pkg::OP_ADDI, ldhc_pkg::OP_ADDIU, ldhc_pkg::OP_SLTI,
                ldhc_pkg::OP_SLTIU, ldhc_pkg::OP_ANDI, ldhc_pkg::OP_ORI,
                ldhc_pkg::OP_XORI, ldhc_pkg::OP_LB, ldhc_pkg::OP_LH,
                ldhc_pkg::OP_LW, ldhc_pkg::OP_LBU, ldhc_pkg::OP_LHU: begin
                    o_access.rd = m_rs;
                    o_access.wr = m_rt;
                end
                ldhc_pkg::OP_LUI: begin
                    o_access.wr = m_rt;
                end
                ldhc_pkg::OP_COP0, ldhc_pkg::OP_COP2: begin
                    // COP2 moves only with a zero funct field
                    if (op == ldhc_pkg::OP_COP0 || fn == 6'd0) begin
                        case (rs)
                            ldhc_pkg::CO_MF, ldhc_pkg::CO_CF: o_access.wr = m_rt;
                            ldhc_pkg::CO_MT, ldhc_pkg::CO_CT: o_access.rd = m_rt;
                            default:                          o_access = '0;
                        endcase
                    end
                end
                ldhc_pkg::OP_LWL, ldhc_pkg::OP_LWR: begin
                    // merge loads: a target match wins, reported as write only
                    o_access.rd = m_rs & ~m_rt;
                    o_access.wr = m_rt;
                end
                ldhc_pkg::OP_SB, ldhc_pkg::OP_SH, ldhc_pkg::OP_SWL,
                ldhc_pkg::OP_SW, ldhc_pkg::OP_SWR: begin
                    o_access.rd = m_rs | m_rt;
                end
                default: o_access = '0;
            endcase
        end
    end

endmodule
